[hdl/cau_pkg.sv]
`timescale 1ns / 1ps
package cau_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               equal_flag;
    logic               zero_divisor;
    logic               overflow_flag;
  } cau_out_t;
endpackage

[hdl/cau_divpipe.sv]
`timescale 1ns / 1ps
module cau_divpipe import cau_pkg::*; #(
  parameter int NB = 97,
  parameter int DB = 65,
  parameter int TB = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NB-1:0]        num,
  input  logic [DB-1:0]        den,
  input  logic [TB-1:0]        tag_in,
  output logic [NB-1:0]        quo,
  output logic [TB-1:0]        tag_out
);
  // One quotient bit per stage, restoring long division on magnitudes.
  logic [NB-1:0] q_s [NB+1];
  logic [DB:0]   r_s [NB+1];
  logic [DB-1:0] d_s [NB+1];
  logic [TB-1:0] t_s [NB+1];

  always_comb begin
    q_s[0] = num;
    r_s[0] = '0;
    d_s[0] = den;
    t_s[0] = tag_in;
  end

  for (genvar i = 0; i < NB; i++) begin : g_st
    logic [DB:0]   trial;
    logic [DB+1:0] diff;
    always_comb begin
      trial = {r_s[i][DB-1:0], q_s[i][NB-1]};
      diff  = {1'b0, trial} - {2'b00, d_s[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i+1] <= diff[DB+1] ? trial : diff[DB:0];
        q_s[i+1] <= {q_s[i][NB-2:0], ~diff[DB+1]};
        d_s[i+1] <= d_s[i];
        t_s[i+1] <= t_s[i];
      end
    end
  end

  assign quo     = q_s[NB];
  assign tag_out = t_s[NB];
endmodule

[hdl/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake         Payload
// in        input      in_valid/in_ready  cau_in_t
// out       output     out_valid/out_ready cau_out_t
// One transaction is accepted per cycle when the output side keeps taking results.
// Latency is set mostly by the bit-per-stage divider.
// Every operation runs through the same pipeline, so order is kept.
// A stall freezes the whole pipeline; reset clears only the valid bits.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cau_in_t  in,
  output logic     out_valid,
  input  logic     out_ready,
  output cau_out_t out
);
  localparam int W  = WORD_BITS_DEF;
  localparam int PW = 2 * W + 1;
  localparam int NB = PW + FRAC_BITS;
  localparam int DEPTH = NB + 5;

  typedef struct packed {
    logic [2:0] kind;
    logic       eq;
    logic       zd;
    logic       nr;
    logic       ni;
  } tag_t;
  localparam int TB = $bits(tag_t);

  logic en;
  logic [DEPTH-1:0] vld;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: register operands.
  cau_in_t s1;
  always_ff @(posedge clk) begin
    if (en) s1 <= in;
  end

  // Stage 2: four products and sums.
  logic signed [2*W-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [W:0] s_r, s_i;
  logic [2:0] k2;
  logic eq2;
  always_ff @(posedge clk) begin
    if (en) begin
      p_rr <= s1.a_real * s1.b_real;
      p_ii <= s1.a_imag * s1.b_imag;
      p_ir <= s1.a_imag * s1.b_real;
      p_ri <= s1.a_real * s1.b_imag;
      k2   <= s1.kind;
      eq2  <= (s1.a_real == s1.b_real) && (s1.a_imag == s1.b_imag);
      if (s1.kind == KIND_SUB) begin
        s_r <= {s1.a_real[W-1], s1.a_real} - {s1.b_real[W-1], s1.b_real};
        s_i <= {s1.a_imag[W-1], s1.a_imag} - {s1.b_imag[W-1], s1.b_imag};
      end else begin
        s_r <= {s1.a_real[W-1], s1.a_real} + {s1.b_real[W-1], s1.b_real};
        s_i <= {s1.a_imag[W-1], s1.a_imag} + {s1.b_imag[W-1], s1.b_imag};
      end
    end
  end

  // Divisor squares need b alone; computed alongside in stage 2.
  logic [2*W-1:0] sq_r, sq_i;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= (2*W)'($signed(s1.b_real) * $signed(s1.b_real));
      sq_i <= (2*W)'($signed(s1.b_imag) * $signed(s1.b_imag));
    end
  end

  // Stage 3: combine products into wide results.
  logic signed [PW-1:0] m_r, m_i, n_r, n_i;
  logic [PW-1:0] den3;
  logic signed [W:0] s_r3, s_i3;
  logic [2:0] k3;
  logic eq3;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= PW'(p_rr) - PW'(p_ii);
      m_i  <= PW'(p_ir) + PW'(p_ri);
      n_r  <= PW'(p_rr) + PW'(p_ii);
      n_i  <= PW'(p_ir) - PW'(p_ri);
      den3 <= {1'b0, sq_r} + {1'b0, sq_i};
      s_r3 <= s_r;
      s_i3 <= s_i;
      k3   <= k2;
      eq3  <= eq2;
    end
  end

  // Stage 4: magnitudes for division, side results staged in a delay line.
  logic [NB-1:0] un_r, un_i;
  logic [PW-1:0] den4;
  tag_t tag4;
  logic signed [W-1:0] side_r4, side_i4;
  logic side_o4;

  function automatic logic [W:0] sat_w(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] mx, mn;
    mx = PW'({1'b0, {(W-1){1'b1}}});
    mn = -mx - PW'(1);
    if (v > mx) return {1'b1, mx[W-1:0]};
    if (v < mn) return {1'b1, mn[W-1:0]};
    return {1'b0, v[W-1:0]};
  endfunction

  logic [W:0] sr_a, si_a;
  logic signed [PW-1:0] mr_sh, mi_sh, nrs, nis;
  always_comb begin
    mr_sh = m_r >>> FRAC_BITS;
    mi_sh = m_i >>> FRAC_BITS;
    if (k3 == KIND_MUL) begin
      sr_a = sat_w(mr_sh);
      si_a = sat_w(mi_sh);
    end else begin
      sr_a = sat_w(PW'(s_r3));
      si_a = sat_w(PW'(s_i3));
    end
    nrs = n_r[PW-1] ? -n_r : n_r;
    nis = n_i[PW-1] ? -n_i : n_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un_r      <= {nrs, {FRAC_BITS{1'b0}}};
      un_i      <= {nis, {FRAC_BITS{1'b0}}};
      den4      <= den3;
      tag4.kind <= k3;
      tag4.eq   <= eq3 && (k3 == KIND_CMP);
      tag4.zd   <= (den3 == '0) && (k3 == KIND_DIV);
      tag4.nr   <= n_r[PW-1];
      tag4.ni   <= n_i[PW-1];
      side_r4   <= sr_a[W-1:0];
      side_i4   <= si_a[W-1:0];
      side_o4   <= sr_a[W] | si_a[W];
    end
  end

  // Side results travel alongside the divider.
  logic [2*W:0] side_q [NB+1];
  always_comb side_q[0] = {side_r4, side_i4, side_o4};
  for (genvar j = 0; j < NB; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side_q[j+1] <= side_q[j];
    end
  end

  logic [NB-1:0] q_r, q_i;
  tag_t tag_r, tag_i;
  cau_divpipe #(.NB(NB), .DB(PW), .TB(TB)) u_div_r (
    .clk(clk), .en(en), .num(un_r), .den(den4), .tag_in(tag4),
    .quo(q_r), .tag_out(tag_r)
  );
  cau_divpipe #(.NB(NB), .DB(PW), .TB(TB)) u_div_i (
    .clk(clk), .en(en), .num(un_i), .den(den4), .tag_in(tag4),
    .quo(q_i), .tag_out(tag_i)
  );

  // Final stage: sign, saturate and select.
  function automatic logic [W:0] sat_q(input logic [NB-1:0] q, input logic neg);
    logic [NB:0] m;
    m = {1'b0, q};
    if (neg) begin
      if (m > (NB+1)'({1'b1, {(W-1){1'b0}}})) return {1'b1, 1'b1, {(W-1){1'b0}}};
      return {1'b0, W'(-m)};
    end
    if (m > (NB+1)'({(W-1){1'b1}})) return {1'b1, 1'b0, {(W-1){1'b1}}};
    return {1'b0, m[W-1:0]};
  endfunction

  logic [W:0] dq_r, dq_i;
  logic [2*W:0] side_o;
  cau_out_t out_next;
  always_comb begin
    dq_r     = sat_q(q_r, tag_r.nr);
    dq_i     = sat_q(q_i, tag_r.ni);
    side_o   = side_q[NB];
    out_next = '0;
    unique case (tag_r.kind)
      KIND_ADD, KIND_SUB, KIND_MUL: begin
        out_next.res_real      = side_o[2*W:W+1];
        out_next.res_imag      = side_o[W:1];
        out_next.overflow_flag = side_o[0];
      end
      KIND_DIV: begin
        if (tag_r.zd) begin
          out_next.zero_divisor = 1'b1;
        end else begin
          out_next.res_real      = dq_r[W-1:0];
          out_next.res_imag      = dq_i[W-1:0];
          out_next.overflow_flag = dq_r[W] | dq_i[W];
        end
      end
      KIND_CMP: out_next.equal_flag = tag_r.eq;
      default: out_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) out <= out_next;
  end

  // tag_i is a duplicate of tag_r; they must agree.
  a_tag_match: assert property (@(posedge clk) disable iff (rst)
    tag_i === tag_r) else $error("tag mismatch");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out.equal_flag, out.zero_divisor, out.overflow_flag}) <= 1)
    else $error("flags conflict");
  a_zd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.zero_divisor |-> out.res_real == 0 && out.res_imag == 0)
    else $error("zero divisor with nonzero result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out))
    else $error("stalled result changed");
endmodule

[dv/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 2 * WORD_BITS_DEF + FRAC_BITS_DEF + 6;
  localparam int HOLD_CYCLES = 3 * LATENCY;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cau_in_t  in_pl = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cau_out_t out_pl;

  cau_in_t  pending_ops[$];
  cau_out_t expected_results[$];
  int       accepted_count = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       failed = 1'b0;

  complex_arithmetic_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in(in_pl),
    .out_valid(out_valid), .out_ready(out_ready), .out(out_pl)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [31:0] saturate(input logic signed [127:0] v,
                                                  inout logic ovf);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = 128'sd2147483647;
    lo_lim = -128'sd2147483648;
    if (v > hi_lim) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < lo_lim) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t x);
    logic signed [127:0] ar, ai, br, bi, pr, pi, den;
    logic ovf;
    cau_out_t r;
    ar = x.a_real;
    ai = x.a_imag;
    br = x.b_real;
    bi = x.b_imag;
    ovf = 1'b0;
    r = '0;
    case (x.kind)
      KIND_ADD: begin
        r.res_real = saturate(ar + br, ovf);
        r.res_imag = saturate(ai + bi, ovf);
      end
      KIND_SUB: begin
        r.res_real = saturate(ar - br, ovf);
        r.res_imag = saturate(ai - bi, ovf);
      end
      KIND_MUL: begin
        pr = ar * br - ai * bi;
        pi = ai * br + bi * ar;
        r.res_real = saturate(pr >>> FRAC, ovf);
        r.res_imag = saturate(pi >>> FRAC, ovf);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.zero_divisor = 1'b1;
        end else begin
          pr = (ar * br + ai * bi) <<< FRAC;
          pi = (ai * br - ar * bi) <<< FRAC;
          r.res_real = saturate(pr / den, ovf);
          r.res_imag = saturate(pi / den, ovf);
        end
      end
      KIND_CMP: begin
        r.equal_flag = (x.a_real == x.b_real) && (x.a_imag == x.b_imag);
      end
      default: begin
      end
    endcase
    r.overflow_flag = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2, 3: return $urandom_range(0, 32'h1fffff) - 32'h100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input logic [2:0] k, input logic [31:0] a_r, input logic [31:0] a_i,
                          input logic [31:0] b_r, input logic [31:0] b_i);
    cau_in_t t;
    t.kind = k;
    t.a_real = a_r;
    t.a_imag = a_i;
    t.b_real = b_r;
    t.b_imag = b_i;
    pending_ops.push_back(t);
  endtask

  function automatic bit sender_idles();
    if (accepted_count < 150) return $urandom_range(0, 99) < 30;
    if (accepted_count < 300) return $urandom_range(0, 99) < 78;
    return 1'b0;
  endfunction

  function automatic bit receiver_idles();
    if (accepted_count < 150) return $urandom_range(0, 99) < 78;
    if (accepted_count < 300) return $urandom_range(0, 99) < 30;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic    next_valid;
    cau_in_t next_pl;
    next_valid = in_valid;
    next_pl = in_pl;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(complex_result(in_pl));
        accepted_count++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_ops.size() > 0 && !sender_idles()) begin
        next_pl = pending_ops.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
    in_pl <= next_pl;
  end

  always @(posedge clk) begin
    cau_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, out_pl);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (out_pl.res_real !== want.res_real)
            $display("%0t: res_real expected %h actual %h", $time, want.res_real,
                     out_pl.res_real);
          if (out_pl.res_imag !== want.res_imag)
            $display("%0t: res_imag expected %h actual %h", $time, want.res_imag,
                     out_pl.res_imag);
          if (out_pl.equal_flag !== want.equal_flag)
            $display("%0t: equal_flag expected %b actual %b", $time, want.equal_flag,
                     out_pl.equal_flag);
          if (out_pl.zero_divisor !== want.zero_divisor)
            $display("%0t: zero_divisor expected %b actual %b", $time, want.zero_divisor,
                     out_pl.zero_divisor);
          if (out_pl.overflow_flag !== want.overflow_flag)
            $display("%0t: overflow_flag expected %b actual %b", $time,
                     want.overflow_flag, out_pl.overflow_flag);
          if (out_pl !== want) failed = 1'b1;
        end
      end
      if (!hold_done && accepted_count >= 320) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !receiver_idles();
      end
    end
  end

  initial begin
    logic [31:0] x, y;
    queue_op(KIND_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
    queue_op(KIND_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_op(KIND_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
    queue_op(KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
    queue_op(KIND_SUB, 32'h00030000, 32'h00000000, 32'h00010000, 32'h00010000);
    queue_op(KIND_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    queue_op(KIND_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    queue_op(KIND_MUL, 32'h00020000, 32'h00010000, 32'hffff0000, 32'h00008000);
    queue_op(KIND_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000);
    queue_op(KIND_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
    queue_op(KIND_DIV, 32'h80000000, 32'h80000000, 32'h00000001, 32'h00000000);
    queue_op(KIND_DIV, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    queue_op(KIND_DIV, 32'hfffe0000, 32'h00010000, 32'h00010000, 32'h00010000);
    queue_op(KIND_DIV, 32'h00000001, 32'hffffffff, 32'h00030000, 32'hfffd0000);
    queue_op(KIND_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
    queue_op(KIND_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
    queue_op(KIND_CMP, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    queue_op(3'd5, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    queue_op(3'd6, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
    queue_op(3'd7, 32'hffffffff, 32'h80000000, 32'h80000000, 32'hffffffff);
    repeat (430) begin
      x = rand_operand();
      y = rand_operand();
      case ($urandom_range(0, 20))
        0: queue_op(3'($urandom_range(5, 7)), x, y, rand_operand(), rand_operand());
        1: queue_op(KIND_CMP, x, y, x, y);
        2: queue_op(KIND_DIV, x, y, 32'h0, 32'h0);
        3: queue_op(KIND_CMP, x, y, x, y ^ (32'h1 << $urandom_range(0, 31)));
        default: queue_op(3'($urandom_range(0, 4)), x, y, rand_operand(), rand_operand());
      endcase
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
